// ----- rtl/rpm_pkg.sv -----
`default_nettype none
package rpm_pkg;

   typedef enum logic [2:0] {
      KIND_GRANT   = 3'd0,
      KIND_CALLER  = 3'd1,
      KIND_POOL    = 3'd2,
      KIND_DESTROY = 3'd3,
      KIND_BUSY    = 3'd4,
      KIND_FAILED  = 3'd5,
      KIND_DONE    = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      ACT_ACQUIRE    = 3'd0,
      ACT_RELEASE    = 3'd1,
      ACT_INVALIDATE = 3'd2,
      ACT_MAINTAIN   = 3'd3,
      ACT_REPLY      = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      CSR_MIN_IDLE   = 2'd0,
      CSR_SOFT_MAX   = 2'd1,
      CSR_HARD_MAX   = 2'd2,
      CSR_EXPIRY_TTL = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_EXP_RD,
      ST_EXP_CHK,
      ST_GRANT,
      ST_GRANT_CHK,
      ST_MAINT,
      ST_TRIM,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] handle;
   } result_type;

endpackage
`default_nettype wire

// ----- rtl/rpm_channels.sv -----
`default_nettype none
interface rpm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic        take_oldest;
   logic [15:0] handle;
   logic [31:0] now_ticks;
   logic        build_ok;
   modport source (output valid, action, take_oldest, handle, now_ticks, build_ok,
                   input ready);
   modport sink (input valid, action, take_oldest, handle, now_ticks, build_ok,
                 output ready);
endinterface

interface rpm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] out_handle;
   logic [4:0]  in_use;
   logic        last;
   modport source (output valid, kind, out_handle, in_use, last, input ready);
   modport sink (input valid, kind, out_handle, in_use, last, output ready);
endinterface

interface rpm_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/resource_pool_manager.sv -----
`default_nettype none
// Pool of resource handles with idle expiry. Idle handles and their release
// or build-reply stamps live in a one-port-write, one-port-read synchronous
// memory used as a newest-first ring. One request item is taken at a time: it
// is decoded, then each expiry check reads the memory and then tests the age
// (preceded by a trim check when trimming above soft_max), each pool
// construction request is issued, and a grant reads the memory and then
// issues its result. The results of an item are collected in a result buffer
// and then delivered one per cycle while the receiver is ready, all carrying
// the final in-use count, the last one flagged. Configuration writes are taken
// at any time, one per cycle.
module resource_pool_manager #(
   parameter int POOL_DEPTH  = 16,
   parameter int HANDLE_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   rpm_req_if.sink   req_port,
   rpm_rsp_if.source rsp_port,
   rpm_csr_if.sink   csr_port
);
   import rpm_pkg::*;

   localparam int PW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CW = $clog2(POOL_DEPTH + 1);
   localparam int LW = (CW + 1 > 5) ? CW + 1 : 5;
   localparam int SW = CW + 1;
   localparam int HW = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
   localparam int DW = HW + 32;
   localparam int RB = POOL_DEPTH + 1;
   localparam int RW = $clog2(RB + 1);
   localparam int BW = (RB > 1) ? $clog2(RB) : 1;

   state_type state_ff, state_in;
   logic [4:0]  min_idle_ff, soft_max_ff, hard_max_ff;
   logic [31:0] ttl_ff;
   logic [CW-1:0] idle_ff, idle_in, total_ff, total_in, pend_ff, pend_in;
   logic [PW-1:0] newest_ff, newest_in;
   logic exp_acq_ff, exp_acq_in, created_ff, created_in;
   logic [2:0]    act_ff;
   logic          oldest_ff;
   logic [HW-1:0] handle_ff;
   logic [31:0]   now_ff;
   logic          ok_ff;
   result_type    rbuf_ff [RB];
   logic [RW-1:0] rcnt_ff, rcnt_in, rptr_ff, rptr_in;

   logic          emit_en;
   result_type    emit_res;
   logic          wr_en, rd_en;
   logic [PW-1:0] wr_addr, rd_addr;
   logic [DW-1:0] rd_data;

   logic [PW-1:0] oldest_slot, newest_next;
   logic [SW-1:0] slot_sum;
   logic [LW-1:0] idle_l, total_l, pend_l, limit_l;
   logic          busy_slot, expired, accept, rsp_fire, is_last;
   logic [31:0]   age;

   rpm_idle_store #(.DEPTH(POOL_DEPTH), .AW(PW), .DW(DW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({now_ff, handle_ff}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      slot_sum = SW'(newest_ff) + SW'(POOL_DEPTH) - (SW'(idle_ff) - SW'(1));
      if (slot_sum >= SW'(POOL_DEPTH)) begin
         slot_sum = slot_sum - SW'(POOL_DEPTH);
      end
      oldest_slot = slot_sum[PW-1:0];
      newest_next = (newest_ff == PW'(POOL_DEPTH - 1)) ? '0 : newest_ff + PW'(1);
   end

   assign idle_l    = LW'(idle_ff);
   assign total_l   = LW'(total_ff);
   assign pend_l    = LW'(pend_ff);
   assign limit_l   = (LW'(hard_max_ff) < LW'(POOL_DEPTH)) ? LW'(hard_max_ff)
                                                           : LW'(POOL_DEPTH);
   assign busy_slot = total_l > idle_l + pend_l;
   assign age       = now_ff - rd_data[DW-1:HW];
   assign expired   = age >= ttl_ff;
   assign accept    = req_port.valid && req_port.ready;
   assign rsp_fire  = rsp_port.valid && rsp_port.ready;
   assign is_last   = rptr_ff == rcnt_ff - RW'(1);

   assign req_port.ready = state_ff == ST_IDLE;
   assign csr_port.ready = 1'b1;
   assign rsp_port.valid = state_ff == ST_DRAIN;
   assign rsp_port.kind       = rbuf_ff[rptr_ff[BW-1:0]].kind;
   assign rsp_port.out_handle = rbuf_ff[rptr_ff[BW-1:0]].handle;
   assign rsp_port.in_use     = (total_ff > idle_ff) ? 5'(total_ff - idle_ff) : 5'd0;
   assign rsp_port.last       = is_last;

   always_comb begin
      state_in   = state_ff;
      idle_in    = idle_ff;
      total_in   = total_ff;
      pend_in    = pend_ff;
      newest_in  = newest_ff;
      exp_acq_in = exp_acq_ff;
      created_in = created_ff;
      rcnt_in    = rcnt_ff;
      rptr_in    = rptr_ff;
      emit_en    = 1'b0;
      emit_res   = '{kind: KIND_DONE, handle: 16'd0};
      wr_en      = 1'b0;
      wr_addr    = newest_next;
      rd_en      = 1'b0;
      rd_addr    = oldest_slot;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in   = ST_DISPATCH;
               created_in = 1'b0;
               rcnt_in    = '0;
               rptr_in    = '0;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_DRAIN;
            emit_en  = 1'b1;
            case (act_ff)
               ACT_ACQUIRE: begin
                  emit_en    = 1'b0;
                  exp_acq_in = 1'b1;
                  state_in   = (ttl_ff != 0 && idle_ff != 0) ? ST_EXP_RD : ST_GRANT;
               end
               ACT_RELEASE: begin
                  if (!busy_slot || idle_l >= LW'(POOL_DEPTH)) begin
                     emit_res = '{kind: KIND_DESTROY, handle: 16'(handle_ff)};
                  end else begin
                     emit_en   = 1'b0;
                     wr_en     = 1'b1;
                     newest_in = newest_next;
                     idle_in   = idle_ff + CW'(1);
                     state_in  = ST_MAINT;
                  end
               end
               ACT_INVALIDATE: begin
                  if (busy_slot) begin
                     total_in = total_ff - CW'(1);
                  end
                  emit_res = '{kind: KIND_DESTROY, handle: 16'(handle_ff)};
               end
               ACT_MAINTAIN: begin
                  emit_en  = 1'b0;
                  state_in = ST_MAINT;
               end
               ACT_REPLY: begin
                  if (ok_ff) begin
                     if (pend_ff != 0 && idle_l < LW'(POOL_DEPTH)) begin
                        pend_in   = pend_ff - CW'(1);
                        wr_en     = 1'b1;
                        newest_in = newest_next;
                        idle_in   = idle_ff + CW'(1);
                     end else begin
                        emit_res = '{kind: KIND_DESTROY, handle: 16'(handle_ff)};
                     end
                  end else begin
                     emit_res = '{kind: KIND_FAILED, handle: 16'd0};
                     if (pend_ff != 0) begin
                        pend_in = pend_ff - CW'(1);
                        if (total_ff != 0) begin
                           total_in = total_ff - CW'(1);
                        end
                     end else if (busy_slot) begin
                        total_in = total_ff - CW'(1);
                     end
                  end
               end
               default: ;
            endcase
         end
         ST_EXP_RD: begin
            rd_en    = 1'b1;
            state_in = ST_EXP_CHK;
         end
         ST_EXP_CHK: begin
            if (expired) begin
               emit_en  = 1'b1;
               emit_res = '{kind: KIND_DESTROY, handle: 16'(rd_data[HW-1:0])};
               idle_in  = idle_ff - CW'(1);
               if (total_ff != 0) begin
                  total_in = total_ff - CW'(1);
               end
               if (exp_acq_ff) begin
                  state_in = (idle_ff != CW'(1)) ? ST_EXP_RD : ST_GRANT;
               end else begin
                  state_in = ST_TRIM;
               end
            end else if (exp_acq_ff) begin
               state_in = ST_GRANT;
            end else begin
               emit_en  = 1'b1;
               state_in = ST_DRAIN;
            end
         end
         ST_GRANT: begin
            if (idle_ff != 0) begin
               rd_en   = 1'b1;
               idle_in = idle_ff - CW'(1);
               if (!oldest_ff) begin
                  rd_addr   = newest_ff;
                  newest_in = (newest_ff == '0) ? PW'(POOL_DEPTH - 1) : newest_ff - PW'(1);
               end
               state_in = ST_GRANT_CHK;
            end else begin
               emit_en  = 1'b1;
               state_in = ST_DRAIN;
               if (total_l < limit_l) begin
                  total_in = total_ff + CW'(1);
                  emit_res = '{kind: KIND_CALLER, handle: 16'd0};
               end else begin
                  emit_res = '{kind: KIND_BUSY, handle: 16'd0};
               end
            end
         end
         ST_GRANT_CHK: begin
            emit_en  = 1'b1;
            emit_res = '{kind: KIND_GRANT, handle: 16'(rd_data[HW-1:0])};
            state_in = ST_DRAIN;
         end
         ST_MAINT: begin
            if (idle_l + pend_l < LW'(min_idle_ff) && total_l < limit_l) begin
               emit_en    = 1'b1;
               emit_res   = '{kind: KIND_POOL, handle: 16'd0};
               pend_in    = pend_ff + CW'(1);
               total_in   = total_ff + CW'(1);
               created_in = 1'b1;
            end else if (created_ff || ttl_ff == 0) begin
               emit_en  = 1'b1;
               state_in = ST_DRAIN;
            end else begin
               exp_acq_in = 1'b0;
               state_in   = ST_TRIM;
            end
         end
         ST_TRIM: begin
            if (idle_l > LW'(soft_max_ff) && idle_ff != 0) begin
               state_in = ST_EXP_RD;
            end else begin
               emit_en  = 1'b1;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_fire) begin
               rptr_in = rptr_ff + RW'(1);
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (emit_en) begin
         rcnt_in = rcnt_ff + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idle_ff     <= '0;
         total_ff    <= '0;
         pend_ff     <= '0;
         newest_ff   <= '0;
         exp_acq_ff  <= 1'b0;
         created_ff  <= 1'b0;
         rcnt_ff     <= '0;
         rptr_ff     <= '0;
         min_idle_ff <= 5'd0;
         soft_max_ff <= 5'd16;
         hard_max_ff <= 5'd16;
         ttl_ff      <= 32'd0;
      end else begin
         state_ff   <= state_in;
         idle_ff    <= idle_in;
         total_ff   <= total_in;
         pend_ff    <= pend_in;
         newest_ff  <= newest_in;
         exp_acq_ff <= exp_acq_in;
         created_ff <= created_in;
         rcnt_ff    <= rcnt_in;
         rptr_ff    <= rptr_in;
         if (csr_port.valid && csr_port.ready) begin
            unique case (csr_index_type'(csr_port.index))
               CSR_MIN_IDLE:   min_idle_ff <= csr_port.data[4:0];
               CSR_SOFT_MAX:   soft_max_ff <= csr_port.data[4:0];
               CSR_HARD_MAX:   hard_max_ff <= csr_port.data[4:0];
               CSR_EXPIRY_TTL: ttl_ff      <= csr_port.data;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff    <= req_port.action;
         oldest_ff <= req_port.take_oldest;
         handle_ff <= req_port.handle[HW-1:0];
         now_ff    <= req_port.now_ticks;
         ok_ff     <= req_port.build_ok;
      end
      if (emit_en) begin
         rbuf_ff[rcnt_ff[BW-1:0]] <= emit_res;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/rpm_idle_store.sv -----
`default_nettype none
module rpm_idle_store #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 48
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output      logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire
